// ----- sv/sts_pkg.sv -----
// Shared types, constants and sizing functions for the smoothed track speed block.
`default_nettype none
package sts_pkg;

    localparam int POS_SMOOTH_HALF_DEF   = 2;
    localparam int SPEED_SMOOTH_HALF_DEF = 1;

    localparam int TIME_W  = 40;
    localparam int POS_W   = 24;
    localparam int GAIN_W  = 32;
    localparam int SPEED_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd162888732;

    // quotient bits produced by the shared divider
    localparam int DIV_STEPS = 16;

    // small signed index/age values and step counter, sized for the full parameter range
    localparam int AGE_W = 6;
    localparam int CNT_W = 5;

    function automatic int seen_max(input int p, input int s);
        int a;
        int b;
        a = 2 * p + 3;
        b = p + s + 2;
        return (a > b) ? a : b;
    endfunction

    function automatic int ext_len(input int p, input int s);
        return 2 * s + 1 + p + 1;
    endfunction

    function automatic int root_w(input int p);
        return POS_W + $clog2(2 * p + 2) + 1;
    endfunction

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TB,
        OP_TA,
        OP_DT,
        OP_SUM,
        OP_SQ,
        OP_ADDSQ,
        OP_SQRT,
        OP_MUL,
        OP_DIVSET,
        OP_DIV,
        OP_WB,
        OP_SACC,
        OP_SDIVSET,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NCHK,
        ST_TB,
        ST_TA,
        ST_DT,
        ST_SUM,
        ST_SQ,
        ST_ADDSQ,
        ST_SQRT,
        ST_MUL,
        ST_DIVSET,
        ST_DIV,
        ST_WB,
        ST_OCHK,
        ST_SACC,
        ST_SDIVSET,
        ST_EMIT,
        ST_FRCHK,
        ST_FOCHK
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_FRAW,
        PH_FOUT
    } phase_t;

    typedef struct packed {
        op_t                     op;
        logic signed [AGE_W-1:0] age;
        logic [CNT_W-1:0]        cnt;
        logic                    append;
        logic                    last;
    } cmd_t;

    typedef struct packed {
        logic signed [AGE_W-1:0] top;
        logic                    dt_nonpos;
        logic                    out_free;
    } stat_t;

endpackage
`default_nettype wire

// ----- sv/sts_dpath.sv -----
// Datapath: point windows, raw speed arithmetic, speed smoothing and output register.
`default_nettype none
module sts_dpath #(
    parameter int POS_SMOOTH_HALF   = sts_pkg::POS_SMOOTH_HALF_DEF,
    parameter int SPEED_SMOOTH_HALF = sts_pkg::SPEED_SMOOTH_HALF_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sts_pkg::cmd_t                     cmd,
    output sts_pkg::stat_t                         stat,
    input  wire logic                              cfg_valid,
    input  wire logic [sts_pkg::GAIN_W-1:0]        cfg_data,
    input  wire logic [sts_pkg::TIME_W-1:0]        time_us,
    input  wire logic signed [sts_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [sts_pkg::POS_W-1:0]  pos_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [sts_pkg::SPEED_W-1:0]            speed_mph,
    output logic                                   last_result
);
    import sts_pkg::*;

    localparam int POS_TAPS = 2 * POS_SMOOTH_HALF + 1;
    localparam int SPD_TAPS = 2 * SPEED_SMOOTH_HALF + 1;
    localparam int SEEN     = seen_max(POS_SMOOTH_HALF, SPEED_SMOOTH_HALF);
    localparam int EXT      = ext_len(POS_SMOOTH_HALF, SPEED_SMOOTH_HALF);
    localparam int WIDX_W   = $clog2(SEEN);
    localparam int SIDX_W   = $clog2(EXT);
    localparam int PS_W     = $clog2(SEEN + 1);
    localparam int LEN_W    = $clog2(EXT + 1);
    localparam int TAPB     = $clog2(POS_TAPS + 1);
    localparam int MAG_W    = POS_W + TAPB;
    localparam int ACC_W    = MAG_W + 1;
    localparam int ROOT_W   = root_w(POS_SMOOTH_HALF);
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int NUM_W    = ROOT_W + GAIN_W;
    localparam int DEN_W    = TIME_W + TAPB + 16;
    localparam int DIV_W    = ((NUM_W > DEN_W + 16) ? NUM_W : DEN_W + 16) + 2;
    localparam int SSUM_W   = SPEED_W + $clog2(SPD_TAPS + 1);

    localparam logic signed [AGE_W-1:0] ONE_S = AGE_W'(1);
    localparam logic signed [AGE_W-1:0] P_S   = AGE_W'(POS_SMOOTH_HALF);
    localparam logic signed [AGE_W-1:0] S_S   = AGE_W'(SPEED_SMOOTH_HALF);

    function automatic logic signed [AGE_W-1:0] clampa(
        input logic signed [AGE_W-1:0] a,
        input logic signed [AGE_W-1:0] hi
    );
        logic signed [AGE_W-1:0] t;
        t = a;
        if (t > hi) t = hi;
        if (t < 0) t = '0;
        return t;
    endfunction

    // track state
    logic signed [POS_W-1:0]  wx_reg [SEEN];
    logic signed [POS_W-1:0]  wy_reg [SEEN];
    logic [TIME_W-1:0]        wt_reg [SEEN];
    logic [PS_W-1:0]          ps_reg;
    logic [SPEED_W-1:0]       seq_reg [EXT];
    logic [SPEED_W-1:0]       seq_next [EXT];
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic [SPEED_W-1:0]       prev_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic                     out_valid_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic                     last_reg;

    // arithmetic
    logic [TIME_W-1:0]        tb_reg;
    logic signed [TIME_W:0]   dt_reg;
    logic                     hold_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [ACC_W-1:0]  accx_reg;
    logic signed [ACC_W-1:0]  accy_reg;
    logic signed [ACC_W-1:0]  accx_next;
    logic signed [ACC_W-1:0]  accy_next;
    logic [2*MAG_W-1:0]       sqx_reg;
    logic [2*MAG_W-1:0]       sqy_reg;
    logic [SQ_W-1:0]          sv_reg;
    logic [SQ_W-1:0]          sr_reg;
    logic [SQ_W-1:0]          sb_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         ds_reg;
    logic [SPEED_W-1:0]       q_reg;
    logic                     sat_reg;
    logic [SSUM_W-1:0]        ssum_reg;
    logic [SSUM_W-1:0]        ssum_next;

    logic signed [AGE_W-1:0]  top;
    logic signed [AGE_W-1:0]  c1;
    logic signed [AGE_W-1:0]  c2;
    logic signed [AGE_W-1:0]  dd;
    logic signed [AGE_W-1:0]  widx;
    logic signed [AGE_W-1:0]  lenm1;
    logic signed [AGE_W-1:0]  sidx;
    logic signed [ACC_W-1:0]  accx_base;
    logic signed [ACC_W-1:0]  accy_base;
    logic signed [ACC_W-1:0]  wxs;
    logic signed [ACC_W-1:0]  wys;
    logic [MAG_W-1:0]         magx;
    logic [MAG_W-1:0]         magy;
    logic [SQ_W-1:0]          trial;
    logic [DIV_W-1:0]         raw_n;
    logic [DIV_W-1:0]         sm_n;
    logic                     wb_first;
    logic [SPEED_W-1:0]       wb_v;

    assign top   = $signed(AGE_W'(ps_reg)) - ONE_S;
    assign c1    = clampa(cmd.age - ONE_S, top);
    assign c2    = clampa(cmd.age + ONE_S, top);
    assign dd    = $signed(AGE_W'(cmd.cnt >> 1)) - P_S;
    assign widx  = cmd.cnt[0] ? clampa(c2 - dd, top) : clampa(c1 - dd, top);
    assign lenm1 = $signed(AGE_W'(len_reg)) - ONE_S;
    assign sidx  = clampa(lenm1 - cmd.age + $signed(AGE_W'(cmd.cnt)) - S_S, lenm1);

    // position sum difference: even steps add the later window, odd steps subtract the earlier
    assign accx_base = (cmd.cnt == '0) ? '0 : accx_reg;
    assign accy_base = (cmd.cnt == '0) ? '0 : accy_reg;
    assign wxs       = ACC_W'(wx_reg[widx[WIDX_W-1:0]]);
    assign wys       = ACC_W'(wy_reg[widx[WIDX_W-1:0]]);
    assign accx_next = cmd.cnt[0] ? accx_base - wxs : accx_base + wxs;
    assign accy_next = cmd.cnt[0] ? accy_base - wys : accy_base + wys;

    assign magx  = MAG_W'(accx_reg[ACC_W-1] ? -accx_reg : accx_reg);
    assign magy  = MAG_W'(accy_reg[ACC_W-1] ? -accy_reg : accy_reg);
    assign trial = sr_reg + sb_reg;

    assign raw_n = DIV_W'(num_reg) + DIV_W'(den_reg >> 1);
    assign sm_n  = DIV_W'(ssum_reg) + DIV_W'(SPD_TAPS / 2);

    assign ssum_next = ((cmd.cnt == '0) ? '0 : ssum_reg) + SSUM_W'(seq_reg[sidx[SIDX_W-1:0]]);

    assign wb_first = (cmd.age == top);
    assign wb_v     = hold_reg ? (wb_first ? '0 : prev_reg) : (sat_reg ? '1 : q_reg);

    always_comb
    begin
        seq_next = seq_reg;
        len_next = len_reg;
        if (cmd.op == OP_WB)
        begin
            if (cmd.append)
            begin
                for (int i = 0; i < EXT; i++)
                begin
                    if (wb_first && (LEN_W'(i) < len_reg)) seq_next[i] = wb_v;
                    if (LEN_W'(i) == len_reg) seq_next[i] = wb_v;
                end
                len_next = len_reg + LEN_W'(1);
            end
            else if (wb_first)
            begin
                for (int i = 0; i < SPD_TAPS; i++) seq_next[i] = wb_v;
            end
            else
            begin
                for (int i = 0; i < SPD_TAPS - 1; i++) seq_next[i] = seq_reg[i + 1];
                seq_next[SPD_TAPS - 1] = wb_v;
            end
        end
        else if (cmd.op == OP_CLEAR)
        begin
            for (int i = 0; i < EXT; i++) seq_next[i] = '0;
            len_next = LEN_W'(SPD_TAPS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEEN; i++)
            begin
                wx_reg[i] <= '0;
                wy_reg[i] <= '0;
                wt_reg[i] <= '0;
            end
            for (int i = 0; i < EXT; i++) seq_reg[i] <= '0;
            ps_reg        <= '0;
            len_reg       <= LEN_W'(SPD_TAPS);
            prev_reg      <= '0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid) gain_reg <= cfg_data;
            seq_reg <= seq_next;
            len_reg <= len_next;
            case (cmd.op)
                OP_LOAD:
                begin
                    for (int i = SEEN - 1; i > 0; i--)
                    begin
                        wx_reg[i] <= wx_reg[i - 1];
                        wy_reg[i] <= wy_reg[i - 1];
                        wt_reg[i] <= wt_reg[i - 1];
                    end
                    wx_reg[0] <= pos_x;
                    wy_reg[0] <= pos_y;
                    wt_reg[0] <= time_us;
                    if (ps_reg < PS_W'(SEEN)) ps_reg <= ps_reg + PS_W'(1);
                end
                OP_WB:
                begin
                    prev_reg <= wb_v;
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < SEEN; i++)
                    begin
                        wx_reg[i] <= '0;
                        wy_reg[i] <= '0;
                        wt_reg[i] <= '0;
                    end
                    ps_reg   <= '0;
                    prev_reg <= '0;
                end
                default:
                begin
                end
            endcase
            if (cmd.op == OP_EMIT) out_valid_reg <= 1'b1;
            else if (out_ready)    out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TB:
            begin
                tb_reg <= wt_reg[c1[WIDX_W-1:0]];
            end
            OP_TA:
            begin
                dt_reg <= $signed({1'b0, tb_reg}) - $signed({1'b0, wt_reg[c2[WIDX_W-1:0]]});
            end
            OP_DT:
            begin
                hold_reg <= stat.dt_nonpos;
                den_reg  <= {(TIME_W + TAPB)'(dt_reg[TIME_W-1:0]) * (TIME_W + TAPB)'(POS_TAPS),
                             16'b0};
            end
            OP_SUM:
            begin
                accx_reg <= accx_next;
                accy_reg <= accy_next;
            end
            OP_SQ:
            begin
                sqx_reg <= (2 * MAG_W)'(magx) * (2 * MAG_W)'(magx);
                sqy_reg <= (2 * MAG_W)'(magy) * (2 * MAG_W)'(magy);
            end
            OP_ADDSQ:
            begin
                sv_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
                sr_reg <= '0;
                sb_reg <= SQ_W'(1) << (2 * (ROOT_W - 1));
            end
            OP_SQRT:
            begin
                if (sv_reg >= trial)
                begin
                    sv_reg <= sv_reg - trial;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg <= sb_reg >> 2;
            end
            OP_MUL:
            begin
                num_reg <= NUM_W'(sr_reg[ROOT_W-1:0]) * NUM_W'(gain_reg);
            end
            OP_DIVSET:
            begin
                rem_reg <= raw_n;
                ds_reg  <= DIV_W'(den_reg) << (DIV_STEPS - 1);
                sat_reg <= raw_n >= (DIV_W'(den_reg) << DIV_STEPS);
                q_reg   <= '0;
            end
            OP_SDIVSET:
            begin
                rem_reg <= sm_n;
                ds_reg  <= DIV_W'(SPD_TAPS) << (DIV_STEPS - 1);
                sat_reg <= 1'b0;
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (rem_reg >= ds_reg)
                begin
                    rem_reg <= rem_reg - ds_reg;
                    q_reg   <= {q_reg[SPEED_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[SPEED_W-2:0], 1'b0};
                end
                ds_reg <= ds_reg >> 1;
            end
            OP_SACC:
            begin
                ssum_reg <= ssum_next;
            end
            OP_EMIT:
            begin
                speed_reg <= q_reg;
                last_reg  <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.top       = top;
    assign stat.dt_nonpos = dt_reg[TIME_W] || (dt_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign speed_mph   = speed_reg;
    assign last_result = last_reg;

endmodule
`default_nettype wire

// ----- sv/sts_ctrl.sv -----
// Controller: sequences raw speed, smoothing and flush steps over the datapath.
`default_nettype none
module sts_ctrl #(
    parameter int POS_SMOOTH_HALF   = sts_pkg::POS_SMOOTH_HALF_DEF,
    parameter int SPEED_SMOOTH_HALF = sts_pkg::SPEED_SMOOTH_HALF_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           end_of_track,
    output sts_pkg::cmd_t       cmd,
    input  wire sts_pkg::stat_t stat
);
    import sts_pkg::*;

    localparam int POS_TAPS = 2 * POS_SMOOTH_HALF + 1;
    localparam int SPD_TAPS = 2 * SPEED_SMOOTH_HALF + 1;
    localparam int ROOT_W   = root_w(POS_SMOOTH_HALF);
    localparam int LAG      = POS_SMOOTH_HALF + SPEED_SMOOTH_HALF + 1;

    localparam logic signed [AGE_W-1:0] AGE_NRAW = AGE_W'(POS_SMOOTH_HALF + 1);
    localparam logic signed [AGE_W-1:0] AGE_LAG  = AGE_W'(LAG);
    localparam logic signed [AGE_W-1:0] AGE_LAG1 = AGE_W'(LAG - 1);
    localparam logic signed [AGE_W-1:0] AGE_P    = AGE_W'(POS_SMOOTH_HALF);
    localparam logic signed [AGE_W-1:0] AGE_S    = AGE_W'(SPEED_SMOOTH_HALF);
    localparam logic signed [AGE_W-1:0] ONE_S    = AGE_W'(1);

    localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(2 * POS_TAPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SACC_LAST = CNT_W'(SPD_TAPS - 1);

    ctl_state_t              state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic signed [AGE_W-1:0] age_reg, age_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    smooth_reg, smooth_next;
    logic                    flush_reg, flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_NORMAL;
            age_reg    <= '0;
            cnt_reg    <= '0;
            smooth_reg <= 1'b0;
            flush_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            age_reg    <= age_next;
            cnt_reg    <= cnt_next;
            smooth_reg <= smooth_next;
            flush_reg  <= flush_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        age_next    = age_reg;
        cnt_next    = cnt_reg;
        smooth_next = smooth_reg;
        flush_next  = flush_reg;
        in_ready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.age     = age_reg;
        cmd.cnt     = cnt_reg;
        cmd.append  = (phase_reg == PH_FRAW);
        cmd.last    = (phase_reg == PH_FOUT) && (age_reg == '0);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    flush_next = end_of_track;
                    phase_next = PH_NORMAL;
                    state_next = ST_NCHK;
                end
            end
            ST_NCHK:
            begin
                if (AGE_NRAW <= stat.top)
                begin
                    age_next   = AGE_NRAW;
                    state_next = ST_TB;
                end
                else
                begin
                    state_next = ST_OCHK;
                end
            end
            ST_TB:
            begin
                cmd.op     = OP_TB;
                state_next = ST_TA;
            end
            ST_TA:
            begin
                cmd.op     = OP_TA;
                state_next = ST_DT;
            end
            ST_DT:
            begin
                cmd.op   = OP_DT;
                cnt_next = '0;
                state_next = stat.dt_nonpos ? ST_WB : ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op   = OP_SUM;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SUM_LAST) state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_ADDSQ;
            end
            ST_ADDSQ:
            begin
                cmd.op     = OP_ADDSQ;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST) state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_DIVSET;
            end
            ST_DIVSET:
            begin
                cmd.op      = OP_DIVSET;
                cnt_next    = '0;
                smooth_next = 1'b0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) state_next = smooth_reg ? ST_EMIT : ST_WB;
            end
            ST_WB:
            begin
                cmd.op = OP_WB;
                if (phase_reg == PH_NORMAL)
                begin
                    state_next = ST_OCHK;
                end
                else
                begin
                    age_next   = age_reg - ONE_S;
                    state_next = ST_FRCHK;
                end
            end
            ST_OCHK:
            begin
                if (AGE_LAG <= stat.top)
                begin
                    age_next   = AGE_S;
                    cnt_next   = '0;
                    state_next = ST_SACC;
                end
                else if (flush_reg)
                begin
                    phase_next = PH_FRAW;
                    age_next   = AGE_P;
                    state_next = ST_FRCHK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SACC:
            begin
                cmd.op   = OP_SACC;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SACC_LAST) state_next = ST_SDIVSET;
            end
            ST_SDIVSET:
            begin
                cmd.op      = OP_SDIVSET;
                cnt_next    = '0;
                smooth_next = 1'b1;
                state_next  = ST_DIV;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (phase_reg == PH_NORMAL)
                    begin
                        if (flush_reg)
                        begin
                            phase_next = PH_FRAW;
                            age_next   = AGE_P;
                            state_next = ST_FRCHK;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        age_next   = age_reg - ONE_S;
                        state_next = ST_FOCHK;
                    end
                end
            end
            ST_FRCHK:
            begin
                if (age_reg[AGE_W-1])
                begin
                    phase_next = PH_FOUT;
                    age_next   = AGE_LAG1;
                    state_next = ST_FOCHK;
                end
                else if (age_reg <= stat.top)
                begin
                    state_next = ST_TB;
                end
                else
                begin
                    age_next = age_reg - ONE_S;
                end
            end
            ST_FOCHK:
            begin
                if (age_reg[AGE_W-1])
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = ST_IDLE;
                end
                else if (age_reg <= stat.top)
                begin
                    cnt_next   = '0;
                    state_next = ST_SACC;
                end
                else
                begin
                    age_next = age_reg - ONE_S;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/smoothed_track_speed_top.sv -----
// Top level of the smoothed track speed block: controller plus datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_ready     | time_us, pos_x, pos_y, end_of_track
//  out      | out_valid / out_ready   | speed_mph, last_result
//  cfg      | cfg_valid / cfg_ready   | cfg_data (speed_gain, Q16.16)
//
// A point is handled one at a time. A raw speed runs through 2*(2*POS_SMOOTH_HALF+1)
// sum steps, the one-bit-per-cycle square root over the root width and the 16-step
// divider; a smoothed output adds 2*SPEED_SMOOTH_HALF+1 accumulate steps plus another
// 16-step pass through the same divider. The end-of-track point adds up to
// POS_SMOOTH_HALF+1 raw speeds and LAG outputs before the track state is cleared. Reset
// clears all windows and restores the default gain. A finished speed sits in the output
// register while the next point is taken; a stalled output only holds the controller
// when a second result is ready to load.
`default_nettype none
module smoothed_track_speed_top #(
    parameter int POS_SMOOTH_HALF   = sts_pkg::POS_SMOOTH_HALF_DEF,
    parameter int SPEED_SMOOTH_HALF = sts_pkg::SPEED_SMOOTH_HALF_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [sts_pkg::TIME_W-1:0]        time_us,
    input  wire logic signed [sts_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [sts_pkg::POS_W-1:0]  pos_y,
    input  wire logic                              end_of_track,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [sts_pkg::SPEED_W-1:0]            speed_mph,
    output logic                                   last_result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sts_pkg::GAIN_W-1:0]        cfg_data
);
    import sts_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // gain register takes a write transaction on any cycle
    assign cfg_ready = 1'b1;

    sts_ctrl #(
        .POS_SMOOTH_HALF   (POS_SMOOTH_HALF),
        .SPEED_SMOOTH_HALF (SPEED_SMOOTH_HALF)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .end_of_track (end_of_track),
        .cmd          (cmd),
        .stat         (stat)
    );

    sts_dpath #(
        .POS_SMOOTH_HALF   (POS_SMOOTH_HALF),
        .SPEED_SMOOTH_HALF (SPEED_SMOOTH_HALF)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .time_us     (time_us),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .speed_mph   (speed_mph),
        .last_result (last_result)
    );

endmodule
`default_nettype wire

// ----- sv/sts_checker.sv -----
// Port-level checker for the smoothed track speed block, bound to the top level.
`default_nettype none
module sts_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic [sts_pkg::TIME_W-1:0]        time_us,
    input wire logic signed [sts_pkg::POS_W-1:0]  pos_x,
    input wire logic signed [sts_pkg::POS_W-1:0]  pos_y,
    input wire logic                              end_of_track,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [sts_pkg::SPEED_W-1:0]       speed_mph,
    input wire logic                              last_result,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [sts_pkg::GAIN_W-1:0]        cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_mph) && $stable(last_result))
        else $error("output changed while stalled");

    // one point in flight: input closes right after a transaction
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // nothing to deliver coming out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("gain write blocked");

endmodule

bind smoothed_track_speed_top sts_checker u_chk (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the smoothed track speed block.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sts_pkg::*;

    // Run shaping
    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 20000;  // cycles with no transaction before giving up
    localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off, fills the block
    localparam int SETTLE       = 1000;   // idle margin before a gain write and at the end

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               last;
    } speed_result_t;

    // Track speed predictor plus the queue of speeds still owed by the block.
    class speed_scoreboard;
        logic [GAIN_W-1:0]  gain;
        longint             win_x[7];
        longint             win_y[7];
        longint             win_t[7];
        logic [SPEED_W-1:0] raw_win[3];
        int                 seen;
        speed_result_t      pending_speeds[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            gain = GAIN_RESET;
            mismatches = 0;
            results_seen = 0;
            clear_track();
        endfunction

        function void clear_track();
            for (int i = 0; i < 7; i++)
            begin
                win_x[i] = 0;
                win_y[i] = 0;
                win_t[i] = 0;
            end
            for (int i = 0; i < 3; i++)
                raw_win[i] = '0;
            seen = 0;
        endfunction

        // append one owed speed at the tail of the queue
        function void queue_speed(logic [SPEED_W-1:0] speed, logic last);
            speed_result_t item;
            item.speed = speed;
            item.last = last;
            pending_speeds.insert(pending_speeds.size(), item);
        endfunction

        function int clamp_age(int a);
            if (a > seen - 1)
                a = seen - 1;
            if (a < 0)
                a = 0;
            return a;
        endfunction

        // sum of the five position taps around a point, edge clamped
        function longint tap_sum(bit use_y, int age);
            int     c;
            int     idx;
            longint s;
            c = clamp_age(age);
            s = 0;
            for (int d = -2; d <= 2; d++)
            begin
                idx = clamp_age(c - d);
                s += use_y ? win_y[idx] : win_x[idx];
            end
            return s;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned cand;
            r = 0;
            for (int i = 30; i >= 0; i--)
            begin
                cand = r | (64'd1 << i);
                if (cand * cand <= v)
                    r = cand;
            end
            return r;
        endfunction

        function logic [SPEED_W-1:0] raw_speed(int age, bit first, logic [SPEED_W-1:0] prev);
            longint          dt;
            longint          dx;
            longint          dy;
            longint unsigned num;
            longint unsigned den;
            longint unsigned v;
            dt = win_t[clamp_age(age - 1)] - win_t[clamp_age(age + 1)];
            // time standing still or going back: hold the previous raw speed
            if (dt <= 0)
                return first ? '0 : prev;
            dx = tap_sum(0, age - 1) - tap_sum(0, age + 1);
            dy = tap_sum(1, age - 1) - tap_sum(1, age + 1);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            num = floor_sqrt(dx * dx + dy * dy) * longint'(gain);
            den = 5 * dt * 65536;
            v = (num + den / 2) / den;
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function logic [SPEED_W-1:0] smooth3(logic [SPEED_W-1:0] seq[6], int len, int center);
            int unsigned sum;
            int          p;
            sum = 0;
            for (int k = -1; k <= 1; k++)
            begin
                p = center + k;
                if (p < 0)
                    p = 0;
                if (p > len - 1)
                    p = len - 1;
                sum += seq[p];
            end
            return SPEED_W'((sum + 1) / 3);
        endfunction

        function void note_point(logic [TIME_W-1:0] t, logic signed [POS_W-1:0] x,
                                 logic signed [POS_W-1:0] y, logic eot);
            int                 top;
            int                 len;
            bit                 first;
            logic [SPEED_W-1:0] v;
            logic [SPEED_W-1:0] seq[6];
            for (int d = 6; d > 0; d--)
            begin
                win_x[d] = win_x[d-1];
                win_y[d] = win_y[d-1];
                win_t[d] = win_t[d-1];
            end
            win_t[0] = longint'(t);
            win_x[0] = x;
            win_y[0] = y;
            if (seen < 7)
                seen++;
            top = seen - 1;
            if (top >= 3)
            begin
                first = (top == 3);
                v = raw_speed(3, first, raw_win[2]);
                if (first)
                    raw_win = '{v, v, v};
                else
                    raw_win = '{raw_win[1], raw_win[2], v};
            end
            for (int i = 0; i < 6; i++)
                seq[i] = (i < 3) ? raw_win[i] : '0;
            if (top >= 4)
                queue_speed(smooth3(seq, 3, 1), 1'b0);
            if (eot)
            begin
                // end of track: the remaining raw speeds, then the lagging outputs
                len = 3;
                for (int age = 2; age >= 0; age--)
                begin
                    if (age > top)
                        continue;
                    first = (age == top);
                    v = raw_speed(age, first, seq[len-1]);
                    if (first)
                        for (int i = 0; i < len; i++)
                            seq[i] = v;
                    seq[len] = v;
                    len++;
                end
                for (int age = 3; age >= 0; age--)
                begin
                    if (age > top)
                        continue;
                    queue_speed(smooth3(seq, len, len - 1 - age), age == 0);
                end
                clear_track();
            end
        endfunction

        function void check_speed(logic [SPEED_W-1:0] speed, logic last);
            speed_result_t want;
            results_seen++;
            if (pending_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected speed %0d last %0b", speed, last);
                return;
            end
            want = pending_speeds.pop_front();
            if (want.speed !== speed || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("speed mismatch: expected %0d last %0b, got %0d last %0b",
                             want.speed, want.last, speed, last);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [TIME_W-1:0]         time_us;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic                      end_of_track;
    logic                      out_valid;
    logic                      out_ready;
    logic [SPEED_W-1:0]        speed_mph;
    logic                      last_result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [GAIN_W-1:0]         cfg_data;

    smoothed_track_speed_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .time_us      (time_us),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .end_of_track (end_of_track),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_mph    (speed_mph),
        .last_result  (last_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    speed_scoreboard sb = new();

    int points_sent = 0;
    int tracks_sent = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;
    bit pressure_req = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Receiver: ready pattern changes in stretches; a requested hold-off keeps ready low
    // long enough for the block to back up and refuse new points.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                out_ready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_req = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
                0: out_ready = 1;                              // never stalls
                1: out_ready = ($urandom_range(0, 1) == 1);
                2: out_ready = ($urandom_range(0, 4) == 0);   // mostly stalled
                default: out_ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Result check and stall watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_speed(speed_mph, last_result);
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d speeds outstanding",
                         STALL_LIMIT, sb.pending_speeds.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // One point transaction. Entered and left on a falling edge; valid stays high
    // across back-to-back points within a burst.
    task automatic send_point(logic [TIME_W-1:0] t, logic signed [POS_W-1:0] x,
                              logic signed [POS_W-1:0] y, logic eot);
        if (burst_left == 0)
        begin
            in_valid = 0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 25)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        time_us = t;
        pos_x = x;
        pos_y = y;
        end_of_track = eot;
        in_valid = 1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_point(t, x, y, eot);
        points_sent++;
        burst_left--;
        if (eot)
            tracks_sent++;
        @(negedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        in_valid = 0;
        cfg_data = g;
        cfg_valid = 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.gain = g;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Wait for every owed speed, then a margin for points still in flight without one.
    task automatic wait_drained();
        in_valid = 0;
        while (sb.pending_speeds.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random track: mostly plausible motion with ascending time, some jumps and
    // time glitches, lengths from single points up past the window depth.
    task automatic random_track();
        int                      len;
        int                      step;
        int                      sel;
        logic [TIME_W-1:0]       t;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            len = $urandom_range(5, 12);
        else if (sel < 8)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(13, 30);
        t = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 1000))
                                        : TIME_W'({$urandom, $urandom});
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        sel = $urandom_range(0, 2);
        step = (sel == 0) ? 300 : (sel == 1) ? 20000 : 0;
        for (int i = 0; i < len; i++)
        begin
            send_point(t, x, y, i == len - 1);
            sel = $urandom_range(0, 19);
            if (sel < 17)
                t = t + TIME_W'($urandom_range(1, 40000));
            else if (sel == 17)
                t = t;                              // repeated timestamp
            else if (sel == 18)
                t = t - TIME_W'($urandom_range(1, 5000));   // time going back
            else
                t = t + TIME_W'($urandom);
            if (step == 0)
            begin
                x = POS_W'($urandom);
                y = POS_W'($urandom);
            end
            else
            begin
                x = x + POS_W'($signed($urandom_range(0, 2 * step)) - step);
                y = y + POS_W'($signed($urandom_range(0, 2 * step)) - step);
            end
        end
    endtask

    initial
    begin
        logic [GAIN_W-1:0] gains[4];
        int                goal;
        rst_n = 0;
        in_valid = 0;
        time_us = '0;
        pos_x = '0;
        pos_y = '0;
        end_of_track = 0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed tracks at the reset gain.
        // single point series
        send_point(40'd0, 24'sd0, 24'sd0, 1);
        // two points at opposite position extremes
        send_point(40'd100, 24'sh7FFFFF, 24'sh800000, 0);
        send_point(40'd200, 24'sh800000, 24'sh7FFFFF, 1);
        // first interval without elapsed time, three points
        send_point(40'd500, 24'sd10, 24'sd20, 0);
        send_point(40'd500, 24'sd900, 24'sd700, 0);
        send_point(40'd520, 24'sd1800, 24'sd1500, 1);
        // full-scale jumps with one microsecond steps: saturates
        for (int i = 0; i < 6; i++)
            send_point(40'd1000 + i, (i % 2) ? 24'sh800000 : 24'sh7FFFFF,
                       (i % 2) ? 24'sh7FFFFF : 24'sh800000, i == 5);
        // repeated and backward timestamps mid-track
        send_point(40'd5000, 24'sd0, 24'sd0, 0);
        send_point(40'd5100, 24'sd3000, -24'sd2000, 0);
        send_point(40'd5100, 24'sd6000, -24'sd4000, 0);
        send_point(40'd4000, 24'sd9000, -24'sd6000, 0);
        send_point(40'd5300, 24'sd12000, -24'sd8000, 1);
        // timestamps at both ends of their range
        send_point(40'd0, -24'sd1, 24'sd1, 0);
        send_point(40'hFF_FFFF_FFFF, 24'sd256, -24'sd256, 0);
        send_point(40'hFF_FFFF_FFFF, 24'sd512, 24'sd512, 1);
        wait_drained();

        // Random phases, one per gain setting: zero, full scale, unity, random.
        gains = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, $urandom};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_gain(gains[ph]);
            if (ph == 1)
                pressure_req = 1;   // long hold-off while points keep coming
            goal = points_sent + RANDOM_ITEMS / 4;
            while (points_sent < goal)
                random_track();
            wait_drained();
        end

        $display("covered %0d points in %0d tracks, %0d speeds checked, over five gain settings",
                 points_sent, tracks_sent, sb.results_seen);
        if (sb.pending_speeds.size() != 0)
        begin
            $display("%0d expected speeds never arrived", sb.pending_speeds.size());
            sb.mismatches++;
        end
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
